@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define NRP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define NRP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `NRP_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

@@ rtl/nrp_pkg.sv @@
// Types and constants for the nearest-rank percentile block.
`default_nettype none

package nrp_pkg;

  localparam int unsigned PCT_W     = 7;
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd50;
  localparam int unsigned RANK_STEP = 100;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PROD,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/nrp_if.sv @@
// Request channel interfaces for samples and results.
`default_nettype none

interface nrp_in_if #(
  parameter int SampleWidth = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample_value;
  logic                          has_sample;
  logic                          end_of_set;

  modport source (output valid, sample_value, has_sample, end_of_set, input ready);
  modport sink   (input valid, sample_value, has_sample, end_of_set, output ready);
endinterface

interface nrp_out_if #(
  parameter int SampleWidth = 32,
  parameter int CountWidth  = 7
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] percentile_value;
  logic [CountWidth-1:0]         sample_count;
  logic                          overflowed;

  modport source (output valid, percentile_value, sample_count, overflowed, input ready);
  modport sink   (input valid, percentile_value, sample_count, overflowed, output ready);
endinterface

`default_nettype wire

@@ rtl/nrp_cell.sv @@
// One cell of the sorted sample chain: insert from the left, shift from the right.
`default_nettype none

module nrp_cell #(
  parameter int Width    = 32,
  parameter int CntWidth = 7,
  parameter int Idx      = 0
) (
  input  wire                     clk_i,
  input  nrp_pkg::cell_ctrl_t     ctrl_i,
  input  wire  [CntWidth-1:0]     count_i,
  input  wire  signed [Width-1:0] sample_i,
  input  wire  signed [Width-1:0] prev_value_i,
  input  wire                     prev_less_i,
  input  wire  signed [Width-1:0] next_value_i,
  output logic signed [Width-1:0] value_o,
  output logic                    less_o
);

  logic signed [Width-1:0] value_q, value_d;
  logic                    empty;

  assign empty   = CntWidth'(Idx) >= count_i;
  assign less_o  = empty || (sample_i < value_q);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.insert && less_o) begin
      value_d = prev_less_i ? prev_value_i : sample_i;
    end else if (ctrl_i.shift) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

@@ rtl/nearest_rank_percentile.sv @@
// Top level of the nearest-rank percentile block.
// Samples enter a sorted cell chain at one request per cycle while loading;
// input waits until the result is registered. A closing request first forms
// percent * n, then the chain shifts toward cell 0 once per rank; the result is
// registered when the output is free. An empty set skips the scan.
// Async active-low reset: empty set, no drop, percent 50, no result pending.
`default_nettype none
`include "assert_macros.svh"

module nearest_rank_percentile #(
  parameter int MAX_SAMPLES  = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [nrp_pkg::PCT_W-1:0]     cfg_wdata_i,
  nrp_in_if.sink                        in_i,
  nrp_out_if.source                     out_o
);

  localparam int CntWidth = $clog2(MAX_SAMPLES + 1);
  localparam int IdxWidth = CntWidth;
  localparam int AccWidth = nrp_pkg::PCT_W + CntWidth;

  nrp_pkg::state_e     state_q, state_d;
  nrp_pkg::cell_ctrl_t ctrl;

  logic [nrp_pkg::PCT_W-1:0] pct_q;
  logic [CntWidth-1:0]       count_q, count_d;
  logic                      drop_q, drop_d;
  logic [AccWidth-1:0]       target_q, target_d;
  logic [AccWidth-1:0]       acc_q, acc_d;
  logic [IdxWidth-1:0]       idx_q, idx_d;

  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] out_value_q, out_value_d;
  logic [CntWidth-1:0]            out_count_q, out_count_d;
  logic                           out_drop_q, out_drop_d;
  logic                           out_free;
  logic                           in_ready;

  logic signed [SAMPLE_WIDTH-1:0] value [MAX_SAMPLES];
  logic                           less  [MAX_SAMPLES];

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] prev_value;
    logic                           prev_less;
    logic signed [SAMPLE_WIDTH-1:0] next_value;

    if (i == 0) begin : g_first
      assign prev_value = in_i.sample_value;
      assign prev_less  = 1'b0;
    end else begin : g_mid
      assign prev_value = value[i-1];
      assign prev_less  = less[i-1];
    end

    if (i == MAX_SAMPLES - 1) begin : g_last
      assign next_value = value[i];
    end else begin : g_body
      assign next_value = value[i+1];
    end

    nrp_cell #(
      .Width    (SAMPLE_WIDTH),
      .CntWidth (CntWidth),
      .Idx      (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .sample_i     (in_i.sample_value),
      .prev_value_i (prev_value),
      .prev_less_i  (prev_less),
      .next_value_i (next_value),
      .value_o      (value[i]),
      .less_o       (less[i])
    );
  end

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    target_d    = target_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_value_d = out_value_q;
    out_count_d = out_count_q;
    out_drop_d  = out_drop_q;
    ctrl        = '0;
    in_ready    = 1'b0;

    unique case (state_q)
      nrp_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.has_sample) begin
            if (count_q != CntWidth'(MAX_SAMPLES)) begin
              ctrl.insert = 1'b1;
              count_d     = count_q + CntWidth'(1);
            end else begin
              drop_d = 1'b1;
            end
          end
          if (in_i.end_of_set) begin
            state_d = nrp_pkg::ST_PROD;
          end
        end
      end
      nrp_pkg::ST_PROD: begin
        target_d = AccWidth'(pct_q) * AccWidth'(count_q);
        acc_d    = AccWidth'(nrp_pkg::RANK_STEP);
        idx_d    = '0;
        if (count_q == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_value_d = '0;
            out_count_d = '0;
            out_drop_d  = drop_q;
            drop_d      = 1'b0;
            state_d     = nrp_pkg::ST_LOAD;
          end
        end else begin
          state_d = nrp_pkg::ST_SCAN;
        end
      end
      nrp_pkg::ST_SCAN: begin
        if ((acc_q >= target_q) || (idx_q == count_q - CntWidth'(1))) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_value_d = value[0];
            out_count_d = count_q;
            out_drop_d  = drop_q;
            count_d     = '0;
            drop_d      = 1'b0;
            state_d     = nrp_pkg::ST_LOAD;
          end
        end else begin
          ctrl.shift = 1'b1;
          acc_d      = acc_q + AccWidth'(nrp_pkg::RANK_STEP);
          idx_d      = idx_q + IdxWidth'(1);
        end
      end
      default: state_d = nrp_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nrp_pkg::ST_LOAD;
      pct_q       <= nrp_pkg::PCT_RESET;
      count_q     <= '0;
      drop_q      <= 1'b0;
      target_q    <= '0;
      acc_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      target_q    <= target_d;
      acc_q       <= acc_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        pct_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_count_q <= out_count_d;
    out_drop_q  <= out_drop_d;
  end

  assign in_i.ready             = in_ready;
  assign out_o.valid            = out_valid_q;
  assign out_o.percentile_value = out_value_q;
  assign out_o.sample_count     = out_count_q;
  assign out_o.overflowed       = out_drop_q;

  `NRP_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntWidth'(MAX_SAMPLES), "count over capacity")
  `NRP_ASSERT(a_drop_full, clk_i, rst_ni, drop_q |-> (count_q == CntWidth'(MAX_SAMPLES)), "drop while not full")
  `NRP_ASSERT(a_scan_idx, clk_i, rst_ni, (state_q == nrp_pkg::ST_SCAN) |-> (idx_q < count_q), "scan past held samples")

  // the scan shifts unheld cells into the held range, so order is only kept outside it
  for (genvar i = 0; i < MAX_SAMPLES - 1; i++) begin : g_chk
    logic in_order;
    assign in_order = (state_q == nrp_pkg::ST_SCAN) || (CntWidth'(i + 1) >= count_q) ||
                      (value[i] <= value[i+1]);
    `NRP_ASSERT(a_sorted, clk_i, rst_ni, in_order, "chain out of order")
  end

endmodule

`default_nettype wire
